// ----- rtl/gmfs_pkg.sv -----
// Shared types and constants for the five-stop gradient map.
// Used by gradient_map_five_stop and tb_gradient_map_five_stop.
`default_nettype none
package gmfs_pkg;

  localparam int RAMP_STEPS_DEF = 2048;
  localparam int NUM_STOPS_DEF  = 5;
  localparam int MAX_STOPS      = 5;
  localparam int STOP_W         = 13;
  localparam int CHAN_W         = 16;
  localparam int COLOR_W        = 64;
  localparam int STOPS4_W       = 52;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_CHAN       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_ONE    = 3'd0,
    CFG_COLOR_TWO    = 3'd1,
    CFG_COLOR_THREE  = 3'd2,
    CFG_COLOR_FOUR   = 3'd3,
    CFG_COLOR_FIVE   = 3'd4,
    CFG_STOPS_FOUR   = 3'd5,
    CFG_STOP_LAST    = 3'd6
  } cfg_idx_t;

  localparam logic [COLOR_W-1:0]  COLOR_ONE_RST  = 64'h0000_0000_0000_FFFF;
  localparam logic [COLOR_W-1:0]  COLOR_REST_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [STOPS4_W-1:0] STOPS4_RST     = 52'd2252074725146624;
  localparam logic [STOP_W-1:0]   STOP_LAST_RST  = 13'd4096;

  typedef struct packed {
    logic [CHAN_W-1:0] luma;
    logic [CHAN_W-1:0] alpha_in;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha_out;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/gmfs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; stage enables come from the top level.
`default_nettype none
module gmfs_div #(
  parameter int DW = 25,
  parameter int QW = 16
) (
  input  wire logic             clk,
  input  wire logic [QW-1:0]    en,
  input  wire logic [QW+DW-1:0] num,
  input  wire logic [DW-1:0]    den,
  output logic      [QW-1:0]    quo
);

  localparam int NW = QW + DW;

  logic [NW-1:0] rem [QW-1];
  logic [DW-1:0] dr  [QW-1];
  logic [QW-1:0] q   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [NW-1:0] trial;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign den_in = dr[j-1];
      assign q_in   = q[j-1];
    end

    assign trial = NW'(den_in) << (QW - 1 - j);
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en[j]) q[j] <= {q_in[QW-2:0], take};
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem[j] <= take ? rem_in - trial : rem_in;
          dr[j]  <= den_in;
        end
      end
    end
  end

  assign quo = q[QW-1];

endmodule
`default_nettype wire

// ----- rtl/gradient_map_five_stop.sv -----
// Five-stop gradient map top level: quantize, segment pick, blend, alpha scale.
// Depends on gmfs_pkg and gmfs_div.
//
//  channel | valid     | stall     | payload
//  pixel   | pix_valid | pix_stall | pix (luma, alpha_in)
//  result  | res_valid | res_stall | res (red, green, blue, alpha_out)
//  config  | cfg_we    | -         | cfg_index, cfg_data
//
// One pixel per cycle while res_stall is low; the pipeline has 6 front stages,
// one divider stage per quotient bit and two alpha stages.
// Reset clears all stage valid bits and loads register reset values.
// A stall holds only the stages that are full; empty stages keep filling.
`default_nettype none
module gradient_map_five_stop #(
  parameter int RAMP_STEPS = gmfs_pkg::RAMP_STEPS_DEF,
  parameter int NUM_STOPS  = gmfs_pkg::NUM_STOPS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pix_valid,
  output logic                              pix_stall,
  input  wire gmfs_pkg::pix_t               pix,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output gmfs_pkg::res_t                    res,
  input  wire logic                         cfg_we,
  input  wire logic [gmfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gmfs_pkg::COLOR_W-1:0] cfg_data
);

  import gmfs_pkg::*;

  localparam int IDXW = $clog2(RAMP_STEPS);
  localparam int RSW  = $clog2(RAMP_STEPS + 1);
  localparam int DW   = STOP_W + RSW;
  localparam int NW   = CHAN_W + DW;
  localparam int XW   = CHAN_W + IDXW;
  localparam int DIV0 = 6;
  localparam int NSTG = DIV0 + CHAN_W + 2;

  localparam logic [IDXW-1:0] RSM1 = IDXW'(RAMP_STEPS - 1);
  localparam logic [DW-1:0]   RS_C = DW'(RAMP_STEPS);

  logic [COLOR_W-1:0] colors [MAX_STOPS];
  logic [STOP_W-1:0]  stops  [MAX_STOPS];
  logic [STOPS4_W-1:0] stops4;
  logic [STOP_W-1:0]  stop_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      colors[0] <= COLOR_ONE_RST;
      for (int i = 1; i < MAX_STOPS; i++) colors[i] <= COLOR_REST_RST;
      stops4    <= STOPS4_RST;
      stop_last <= STOP_LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_ONE:   colors[0] <= cfg_data;
        CFG_COLOR_TWO:   colors[1] <= cfg_data;
        CFG_COLOR_THREE: colors[2] <= cfg_data;
        CFG_COLOR_FOUR:  colors[3] <= cfg_data;
        CFG_COLOR_FIVE:  colors[4] <= cfg_data;
        CFG_STOPS_FOUR:  stops4    <= cfg_data[STOPS4_W-1:0];
        CFG_STOP_LAST:   stop_last <= cfg_data[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STOPS - 1; i++) stops[i] = stops4[i*STOP_W +: STOP_W];
    stops[MAX_STOPS-1] = stop_last;
  end

  // stage control: a stage loads when empty or when the next one moves
  logic [NSTG-1:0] v;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !v[NSTG-1] || !res_stall;
    for (int i = NSTG - 2; i >= 0; i--) rdy[i] = !v[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= pix_valid;
      for (int i = 1; i < NSTG; i++) if (rdy[i]) v[i] <= v[i-1];
    end
  end

  assign pix_stall = !rdy[0];
  assign res_valid = v[NSTG-1];

  logic [CHAN_W-1:0] ain [NSTG-2];

  always_ff @(posedge clk) begin
    if (rdy[0]) ain[0] <= pix.alpha_in;
    for (int i = 1; i < NSTG - 2; i++) if (rdy[i]) ain[i] <= ain[i-1];
  end

  // stage 0: luma times (steps - 1)
  logic [XW-1:0] x0;
  always_ff @(posedge clk) begin
    if (rdy[0]) x0 <= XW'(pix.luma) * XW'(RSM1);
  end

  // stage 1: divide by 65535
  logic [IDXW-1:0] q0;
  logic [CHAN_W:0] r0;
  logic [IDXW-1:0] idx1;
  assign q0 = x0[XW-1:CHAN_W];
  assign r0 = {1'b0, x0[CHAN_W-1:0]} + (CHAN_W+1)'(q0);
  always_ff @(posedge clk) begin
    if (rdy[1]) idx1 <= q0 + IDXW'(r0 >= (CHAN_W+1)'(65535));
  end

  // stage 2: segment pick
  logic [DW-1:0]      scaled1;
  logic [STOP_W-1:0]  lo_c, hi_c;
  logic [COLOR_W-1:0] ca_c, cb_c;
  logic               found;
  assign scaled1 = DW'(idx1) << 12;

  always_comb begin
    found = 1'b0;
    lo_c  = '0;
    hi_c  = '0;
    ca_c  = colors[NUM_STOPS-1];
    cb_c  = colors[NUM_STOPS-1];
    for (int n = 1; n < NUM_STOPS; n++) begin
      if (!found && (DW'(stops[n]) * RS_C >= scaled1)) begin
        found = 1'b1;
        lo_c  = stops[n-1];
        hi_c  = stops[n];
        ca_c  = colors[n-1];
        cb_c  = colors[n];
      end
    end
  end

  logic [IDXW-1:0]    idx2;
  logic [STOP_W-1:0]  lo2, hi2;
  logic [COLOR_W-1:0] ca2, cb2;
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      idx2 <= idx1;
      lo2  <= lo_c;
      hi2  <= hi_c;
      ca2  <= ca_c;
      cb2  <= cb_c;
    end
  end

  // stage 3: weight as num over den
  logic [DW-1:0] scaled2, lors, hirs, diff, den_c, num_c;
  assign scaled2 = DW'(idx2) << 12;
  assign lors    = DW'(lo2) * RS_C;
  assign hirs    = DW'(hi2) * RS_C;
  assign diff    = scaled2 - lors;

  always_comb begin
    if (hi2 <= lo2) begin
      den_c = DW'(1);
      num_c = DW'(1);
    end else begin
      den_c = hirs - lors;
      if (scaled2 <= lors) num_c = '0;
      else if (diff > den_c) num_c = den_c;
      else num_c = diff;
    end
  end

  logic [DW-1:0]      den3, num3;
  logic [COLOR_W-1:0] ca3, cb3;
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      den3 <= den_c;
      num3 <= num_c;
      ca3  <= ca2;
      cb3  <= cb2;
    end
  end

  // stage 4: per-channel products
  logic [NW-1:0] plo4 [NUM_CHAN];
  logic [NW-1:0] phi4 [NUM_CHAN];
  logic [DW-1:0] den4;
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      den4 <= den3;
      for (int c = 0; c < NUM_CHAN; c++) begin
        plo4[c] <= NW'(ca3[COLOR_W-1-CHAN_W*c -: CHAN_W]) * NW'(den3 - num3);
        phi4[c] <= NW'(cb3[COLOR_W-1-CHAN_W*c -: CHAN_W]) * NW'(num3);
      end
    end
  end

  // stage 5: sum with rounding
  logic [NW-1:0] n5 [NUM_CHAN];
  logic [DW-1:0] den5;
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      den5 <= den4;
      for (int c = 0; c < NUM_CHAN; c++) n5[c] <= plo4[c] + phi4[c] + NW'(den4 >> 1);
    end
  end

  logic [CHAN_W-1:0] quo [NUM_CHAN];
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_div
    gmfs_div #(.DW(DW), .QW(CHAN_W)) u_div (
      .clk (clk),
      .en  (rdy[DIV0 +: CHAN_W]),
      .num (n5[c]),
      .den (den5),
      .quo (quo[c])
    );
  end

  // alpha scale stages
  localparam int AS = DIV0 + CHAN_W;
  logic [2*CHAN_W-1:0] ax;
  logic [CHAN_W-1:0]   rd_a, gr_a, bl_a;
  always_ff @(posedge clk) begin
    if (rdy[AS]) begin
      ax   <= (2*CHAN_W)'(quo[3]) * (2*CHAN_W)'(ain[AS-1]) + (2*CHAN_W)'(32767);
      rd_a <= quo[0];
      gr_a <= quo[1];
      bl_a <= quo[2];
    end
  end

  logic [CHAN_W:0] aq0, ar0, aq;
  assign aq0 = {1'b0, ax[2*CHAN_W-1:CHAN_W]};
  assign ar0 = {1'b0, ax[CHAN_W-1:0]} + aq0;
  assign aq  = aq0 + (CHAN_W+1)'(ar0 >= (CHAN_W+1)'(65535))
                   + (CHAN_W+1)'(ar0 >= (CHAN_W+1)'(131070));

  always_ff @(posedge clk) begin
    if (rdy[AS+1]) begin
      res.red       <= rd_a;
      res.green     <= gr_a;
      res.blue      <= bl_a;
      res.alpha_out <= aq[CHAN_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_enter: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall |=> v[0])
    else $error("accepted transfer did not enter stage 0");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    v[5] |-> den5 != '0)
    else $error("zero divisor reached divider");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    v[NSTG-2] && !(res_valid && res_stall) |=> res_valid)
    else $error("result lost between last stages");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v[0] && pix_stall |=> v[0])
    else $error("stalled front stage dropped its item");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_gradient_map_five_stop.sv -----
// Self-checking testbench for gradient_map_five_stop: pixel driver, result monitor,
// predicted-color queue and configuration phases with random idling.
// Depends on gmfs_pkg and the gradient_map_five_stop RTL.
`timescale 1ns / 1ps
module tb_gradient_map_five_stop;
  import gmfs_pkg::*;

  localparam int STEPS = 2048;
  localparam int LATENCY = 24;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pix_t pix = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0] cfg_data = '0;

  gradient_map_five_stop dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [COLOR_W-1:0] ramp_color [5];
  logic [STOPS4_W-1:0] stop_lanes;
  logic [STOP_W-1:0] stop_five;

  pix_t pending_pix[$];
  res_t expected_color[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic longint stop_at(int n);
    if (n >= 4) return longint'(stop_five);
    return longint'((stop_lanes >> (STOP_W * n)) & 52'h1FFF);
  endfunction

  function automatic res_t map_pixel(pix_t p);
    res_t r;
    longint idx, scaled, lo, hi, den, num;
    longint unsigned a, b, v;
    logic [15:0] ch [4];
    int k;
    idx = (longint'(p.luma) * (STEPS - 1)) / 65535;
    scaled = idx * 4096;
    k = 0;
    for (int n = 1; n < 5; n++)
      if (k == 0 && stop_at(n) * STEPS >= scaled) k = n;
    for (int c = 0; c < 4; c++) begin
      if (k == 0) begin
        ch[c] = ramp_color[4][48 - 16 * c +: 16];
      end else begin
        lo = stop_at(k - 1);
        hi = stop_at(k);
        if (hi <= lo) begin
          den = 1;
          num = 1;
        end else begin
          den = (hi - lo) * STEPS;
          num = scaled - lo * STEPS;
          if (num < 0) num = 0;
          if (num > den) num = den;
        end
        a = ramp_color[k - 1][48 - 16 * c +: 16];
        b = ramp_color[k][48 - 16 * c +: 16];
        v = (a * (den - num) + b * num + den / 2) / den;
        ch[c] = v[15:0];
      end
    end
    r.red = ch[0];
    r.green = ch[1];
    r.blue = ch[2];
    v = (longint'(ch[3]) * p.alpha_in + 32767) / 65535;
    r.alpha_out = v[15:0];
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // driver: advance on transfer, otherwise hold
  always @(posedge clk) begin
    if (!rst) begin
      if (!pix_valid || !pix_stall) begin
        if (pending_pix.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pix <= pending_pix[0];
          expected_color.push_back(map_pixel(pending_pix[0]));
          pending_pix.pop_front();
          pix_valid <= 1'b1;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (expected_color.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", res);
        end else begin
          if (res !== expected_color[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %h actual %h", expected_color[0], res);
          end
          expected_color.pop_front();
        end
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_idx_t which, logic [COLOR_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      CFG_STOPS_FOUR: stop_lanes = value[STOPS4_W-1:0];
      CFG_STOP_LAST: stop_five = value[STOP_W-1:0];
      default: ramp_color[which] = value;
    endcase
  endtask

  task automatic drain();
    while (pending_pix.size() > 0 || pix_valid || expected_color.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [STOPS4_W-1:0] pack_stops(int s1, int s2, int s3, int s4);
    return {13'(s4), 13'(s3), 13'(s2), 13'(s1)};
  endfunction

  task automatic queue_random(int count);
    pix_t p;
    for (int i = 0; i < count; i++) begin
      p.luma = 16'($urandom);
      p.alpha_in = 16'($urandom);
      if ($urandom_range(9) == 0) p.luma = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(9) == 0) p.alpha_in = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      pending_pix.push_back(p);
    end
  endtask

  task automatic random_colors();
    for (int c = 0; c < 5; c++)
      write_reg(cfg_idx_t'(c), {$urandom, $urandom});
  endtask

  initial begin
    int s [5];
    int tmp;
    ramp_color[0] = COLOR_ONE_RST;
    for (int c = 1; c < 5; c++) ramp_color[c] = COLOR_REST_RST;
    stop_lanes = STOPS4_RST;
    stop_five = STOP_LAST_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset ramp, field extremes
    pending_pix.push_back('{16'h0000, 16'hFFFF});
    pending_pix.push_back('{16'hFFFF, 16'hFFFF});
    pending_pix.push_back('{16'h8000, 16'h0000});
    pending_pix.push_back('{16'h0020, 16'h8000});
    drain();

    // directed: evenly spaced stops, then equal and descending stops with a last
    // stop below the top (past the end), then all stops above 1.0
    write_reg(CFG_COLOR_ONE, 64'h0000_1111_2222_3333);
    write_reg(CFG_COLOR_TWO, 64'hFFFF_0000_8000_FFFF);
    write_reg(CFG_COLOR_THREE, 64'h1234_5678_9ABC_DEF0);
    write_reg(CFG_COLOR_FOUR, 64'h0001_FFFE_7FFF_8000);
    write_reg(CFG_COLOR_FIVE, 64'hAAAA_5555_0F0F_F0F0);
    write_reg(CFG_STOPS_FOUR, 64'(pack_stops(0, 1024, 2048, 3072)));
    write_reg(CFG_STOP_LAST, 64'd4096);
    for (int i = 0; i < 8; i++)
      pending_pix.push_back('{16'(i * 9362), 16'(i * 9362)});
    drain();
    write_reg(CFG_STOPS_FOUR, 64'(pack_stops(1000, 1000, 3000, 2000)));
    write_reg(CFG_STOP_LAST, 64'hFFFF_FFFF_FFFF_0800);
    for (int i = 0; i < 6; i++)
      pending_pix.push_back('{16'(i * 13107), 16'hFFFF});
    drain();
    write_reg(CFG_STOPS_FOUR, 64'(pack_stops(8191, 8191, 8191, 8191)));
    write_reg(CFG_STOP_LAST, 64'd8191);
    pending_pix.push_back('{16'hFFFF, 16'h7FFF});
    pending_pix.push_back('{16'h0000, 16'h0001});
    drain();

    // random phases across idling modes and ramp settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 53; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 53; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      random_colors();
      for (int n = 0; n < 5; n++) s[n] = $urandom_range(4096);
      if (ph % 3 != 2) begin
        for (int i = 0; i < 5; i++)
          for (int j = 0; j < 4 - i; j++)
            if (s[j] > s[j + 1]) begin
              tmp = s[j]; s[j] = s[j + 1]; s[j + 1] = tmp;
            end
      end else begin
        for (int n = 0; n < 5; n++) s[n] = $urandom_range(8191);
      end
      if (ph == 4) begin
        s[0] = 0; s[4] = 4096;
      end
      write_reg(CFG_STOPS_FOUR, {$urandom, $urandom});
      write_reg(CFG_STOPS_FOUR, 64'(pack_stops(s[0], s[1], s[2], s[3])));
      write_reg(CFG_STOP_LAST, 64'(s[4]));
      queue_random(178);
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
